// ----- rtl/core/mbup_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI byte to USB event packer package
// Shared constants and the per-cable parser state type.
// ----------------------------------------------------------------------------
package mbup_pkg;

    // Number of MIDI-IN jacks; the cable field is fixed at two bits
    localparam int CABLES      = 4;
    localparam int CABLE_W     = 2;
    localparam int CABLE_OUT_W = 4;
    localparam int CIDX_W      = (CABLES > 1) ? $clog2(CABLES) : 1;

    // Parser phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT1 = 3'd1;
    localparam logic [2:0] PH_WAIT2 = 3'd2;
    localparam logic [2:0] PH_SYSEX = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // Message kind codes
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_ONE   = 3'd1;
    localparam logic [2:0] KIND_TWO   = 3'd2;
    localparam logic [2:0] KIND_THREE = 3'd3;
    localparam logic [2:0] KIND_SYSEX = 3'd4;

    // MIDI status bytes with special handling
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_FIRST_ONE   = 8'hF4;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_PROG_CHANGE = 8'hC0;
    localparam logic [7:0] ST_PITCH_BEND  = 8'hE0;

    // USB-MIDI code index numbers
    localparam logic [3:0] CIN_SYS_TWO    = 4'h2;
    localparam logic [3:0] CIN_SYS_THREE  = 4'h3;
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
    localparam logic [3:0] CIN_SINGLE     = 4'hF;

    // Per-cable parser state, one memory word
    typedef struct packed {
        logic [2:0] parse_phase;
        logic [2:0] message_kind;
        logic       system_flag;
        logic [7:0] held_first;
        logic [7:0] held_second;
        logic [1:0] sysex_held_count;
    } parser_state_t;

    localparam parser_state_t STATE_RESET = '0;

endpackage

// ----- rtl/core/midi_byte_to_usb_event_packer.sv -----
// ----------------------------------------------------------------------------
// MIDI byte to USB event packer
// Parses tagged serial MIDI bytes per cable and builds USB-MIDI event packets.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid / byte_stall): one beat carries a received MIDI
//   byte (rx_byte) and the cable (MIDI-IN jack) it came from. Packet channel
//   (packet_valid / packet_stall): one beat carries a USB-MIDI event packet:
//   cable_out, code_index and byte1..byte3, unused bytes zero. A byte yields
//   zero or one packet.
//   Output: packet_valid rises as the completing byte leaves the parse stage
//   and its packet is written into the output register.
//   Throughput: one byte per cycle while byte_stall is low. Per-cable state
//   sits in a 4-word memory with a registered read; a byte reads its cable's
//   word when taken and writes it back when it leaves the parse stage; a byte
//   for its cable right behind uses the forwarded write, not the stale read.
//   Reset: all parsers return to idle at once; a valid bit per word makes an
//   unwritten word read as the idle state, so no clearing pass is needed.
//   Stall: while packet_stall holds a packet, a byte that would emit another
//   waits in the parse stage and byte_stall rises; bytes that emit nothing
//   pass through regardless.
// ----------------------------------------------------------------------------
module midi_byte_to_usb_event_packer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               byte_valid,
    output logic                               byte_stall,
    input  logic [mbup_pkg::CABLE_W-1:0]       cable,
    input  logic [7:0]                         rx_byte,
    output logic                               packet_valid,
    input  logic                               packet_stall,
    output logic [mbup_pkg::CABLE_OUT_W-1:0]   cable_out,
    output logic [3:0]                         code_index,
    output logic [7:0]                         byte1,
    output logic [7:0]                         byte2,
    output logic [7:0]                         byte3
);

    // Parser state memory, one word per cable, with reset-cleared valid bits
    mbup_pkg::parser_state_t state_mem [mbup_pkg::CABLES];
    logic [mbup_pkg::CABLES-1:0] entry_valid_reg;

    // Parse stage registers
    logic                           s1_valid_reg;
    logic [mbup_pkg::CABLE_W-1:0]   s1_cable_reg;
    logic [7:0]                     s1_byte_reg;
    mbup_pkg::parser_state_t        rd_data_reg;
    logic                           rd_valid_reg;
    logic                           fwd_reg;
    mbup_pkg::parser_state_t        wr_data_reg;

    // Output register
    logic                           packet_valid_reg;
    logic [mbup_pkg::CABLE_OUT_W-1:0] cable_out_reg;
    logic [3:0]                     code_index_reg;
    logic [7:0]                     byte1_reg;
    logic [7:0]                     byte2_reg;
    logic [7:0]                     byte3_reg;

    logic                           byte_accept;
    logic                           cable_ok;
    logic                           s1_ok;
    logic                           s1_adv;
    logic                           s1_write;
    logic [mbup_pkg::CIDX_W-1:0]    rd_idx;
    logic [mbup_pkg::CIDX_W-1:0]    wr_idx;
    mbup_pkg::parser_state_t        cur;
    mbup_pkg::parser_state_t        nxt;
    logic                           emit;
    logic [3:0]                     emit_cin;
    logic [7:0]                     emit_b1;
    logic [7:0]                     emit_b2;
    logic [7:0]                     emit_b3;
    logic [3:0]                     msg_cin;

    assign rd_idx = mbup_pkg::CIDX_W'(cable);
    assign wr_idx = mbup_pkg::CIDX_W'(s1_cable_reg);
    assign cable_ok = (int'(cable) < mbup_pkg::CABLES);
    assign s1_ok = (int'(s1_cable_reg) < mbup_pkg::CABLES);

    // Current word: forwarded write, else memory, else idle if never written
    always_comb
    begin
        if (fwd_reg)
            cur = wr_data_reg;
        else if (rd_valid_reg)
            cur = rd_data_reg;
        else
            cur = mbup_pkg::STATE_RESET;
    end

    // Code index of a completed channel or system common message
    always_comb
    begin
        if (cur.system_flag)
            msg_cin = (cur.message_kind == mbup_pkg::KIND_THREE) ?
                      mbup_pkg::CIN_SYS_THREE : mbup_pkg::CIN_SYS_TWO;
        else
            msg_cin = cur.held_first[7:4];
    end

    // Parser step for one byte
    always_comb
    begin
        nxt      = cur;
        emit     = 1'b0;
        emit_cin = '0;
        emit_b1  = '0;
        emit_b2  = '0;
        emit_b3  = '0;
        if (s1_byte_reg[7])
        begin
            if (s1_byte_reg == mbup_pkg::ST_SYSEX_END)
            begin
                nxt.parse_phase      = mbup_pkg::PH_IDLE;
                nxt.system_flag      = 1'b1;
                nxt.sysex_held_count = 2'd0;
                if (cur.parse_phase == mbup_pkg::PH_SYSEX)
                begin
                    // Close the SysEx with whatever bytes are held
                    nxt.message_kind = mbup_pkg::KIND_SYSEX;
                    emit = 1'b1;
                    if (cur.sysex_held_count == 2'd0)
                    begin
                        emit_cin = mbup_pkg::CIN_SYSEX_END1;
                        emit_b1  = mbup_pkg::ST_SYSEX_END;
                    end
                    else if (cur.sysex_held_count == 2'd1)
                    begin
                        emit_cin = mbup_pkg::CIN_SYSEX_END2;
                        emit_b1  = cur.held_first;
                        emit_b2  = mbup_pkg::ST_SYSEX_END;
                    end
                    else
                    begin
                        emit_cin = mbup_pkg::CIN_SYSEX_END3;
                        emit_b1  = cur.held_first;
                        emit_b2  = cur.held_second;
                        emit_b3  = mbup_pkg::ST_SYSEX_END;
                    end
                end
                else
                    nxt.message_kind = mbup_pkg::KIND_NONE;
            end
            else if (s1_byte_reg >= mbup_pkg::ST_FIRST_ONE)
            begin
                // Single-byte system message goes out at once
                nxt.held_first       = s1_byte_reg;
                nxt.parse_phase      = mbup_pkg::PH_IDLE;
                nxt.message_kind     = mbup_pkg::KIND_ONE;
                nxt.system_flag      = 1'b1;
                nxt.sysex_held_count = 2'd0;
                emit     = 1'b1;
                emit_cin = mbup_pkg::CIN_SINGLE;
                emit_b1  = s1_byte_reg;
            end
            else
            begin
                // Any other status starts a new message and drops a SysEx
                nxt.held_first       = s1_byte_reg;
                nxt.held_second      = 8'd0;
                nxt.sysex_held_count = 2'd0;
                nxt.parse_phase      = mbup_pkg::PH_WAIT1;
                if (s1_byte_reg == mbup_pkg::ST_SYSEX_START)
                begin
                    nxt.message_kind     = mbup_pkg::KIND_SYSEX;
                    nxt.system_flag      = 1'b1;
                    nxt.parse_phase      = mbup_pkg::PH_SYSEX;
                    nxt.sysex_held_count = 2'd1;
                end
                else if (s1_byte_reg == mbup_pkg::ST_MTC_QFRAME ||
                         s1_byte_reg == mbup_pkg::ST_SONG_SEL)
                begin
                    nxt.message_kind = mbup_pkg::KIND_TWO;
                    nxt.system_flag  = 1'b1;
                end
                else if (s1_byte_reg == mbup_pkg::ST_SONG_POS)
                begin
                    nxt.message_kind = mbup_pkg::KIND_THREE;
                    nxt.system_flag  = 1'b1;
                end
                else if (s1_byte_reg >= mbup_pkg::ST_PROG_CHANGE &&
                         s1_byte_reg <  mbup_pkg::ST_PITCH_BEND)
                begin
                    nxt.message_kind = mbup_pkg::KIND_TWO;
                    nxt.system_flag  = 1'b0;
                end
                else
                begin
                    nxt.message_kind = mbup_pkg::KIND_THREE;
                    nxt.system_flag  = 1'b0;
                end
            end
        end
        else
        begin
            unique case (cur.parse_phase) inside
                mbup_pkg::PH_WAIT1, mbup_pkg::PH_DONE:
                begin
                    // Running status applies only after a channel message
                    if (!(cur.parse_phase == mbup_pkg::PH_DONE && cur.system_flag))
                    begin
                        nxt.held_second = s1_byte_reg;
                        if (cur.message_kind == mbup_pkg::KIND_THREE)
                            nxt.parse_phase = mbup_pkg::PH_WAIT2;
                        else if (cur.message_kind == mbup_pkg::KIND_TWO)
                        begin
                            nxt.parse_phase = cur.system_flag ?
                                              mbup_pkg::PH_IDLE : mbup_pkg::PH_DONE;
                            emit     = 1'b1;
                            emit_cin = msg_cin;
                            emit_b1  = cur.held_first;
                            emit_b2  = s1_byte_reg;
                        end
                        else
                            nxt.parse_phase = mbup_pkg::PH_IDLE;
                    end
                end
                mbup_pkg::PH_WAIT2:
                begin
                    if (cur.message_kind != mbup_pkg::KIND_THREE)
                        nxt.parse_phase = mbup_pkg::PH_IDLE;
                    else
                    begin
                        nxt.parse_phase = cur.system_flag ?
                                          mbup_pkg::PH_IDLE : mbup_pkg::PH_DONE;
                        emit     = 1'b1;
                        emit_cin = msg_cin;
                        emit_b1  = cur.held_first;
                        emit_b2  = cur.held_second;
                        emit_b3  = s1_byte_reg;
                    end
                end
                mbup_pkg::PH_SYSEX:
                begin
                    // Hold two bytes, send a packet on the third
                    if (cur.sysex_held_count == 2'd0)
                    begin
                        nxt.held_first       = s1_byte_reg;
                        nxt.sysex_held_count = 2'd1;
                    end
                    else if (cur.sysex_held_count == 2'd1)
                    begin
                        nxt.held_second      = s1_byte_reg;
                        nxt.sysex_held_count = 2'd2;
                    end
                    else
                    begin
                        nxt.sysex_held_count = 2'd0;
                        emit     = 1'b1;
                        emit_cin = mbup_pkg::CIN_SYSEX_CONT;
                        emit_b1  = cur.held_first;
                        emit_b2  = cur.held_second;
                        emit_b3  = s1_byte_reg;
                    end
                end
                default:
                begin
                    // Drop stray data while idle
                end
            endcase
        end
    end

    // Advance the parse stage unless its packet has no room
    assign s1_adv      = s1_valid_reg && (!(emit && s1_ok) || !packet_valid_reg ||
                                          !packet_stall);
    assign s1_write    = s1_adv && s1_ok;
    assign byte_stall  = s1_valid_reg && !s1_adv;
    assign byte_accept = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            packet_valid_reg <= 1'b0;
            entry_valid_reg  <= '0;
            fwd_reg          <= 1'b0;
        end
        else
        begin
            if (byte_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_write && (s1_cable_reg == cable);
            end
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_write)
                entry_valid_reg[wr_idx] <= 1'b1;

            if (s1_write && emit)
                packet_valid_reg <= 1'b1;
            else if (!packet_stall)
                packet_valid_reg <= 1'b0;
        end
    end

    // State memory: read at accept, write back on advance
    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            state_mem[wr_idx] <= nxt;
            wr_data_reg       <= nxt;
        end
        if (byte_accept)
        begin
            if (cable_ok)
                rd_data_reg <= state_mem[rd_idx];
            rd_valid_reg <= cable_ok && entry_valid_reg[rd_idx];
            s1_cable_reg <= cable;
            s1_byte_reg  <= rx_byte;
        end
    end

    // Packet payload
    always_ff @(posedge clk)
    begin
        if (s1_write && emit)
        begin
            cable_out_reg  <= mbup_pkg::CABLE_OUT_W'(s1_cable_reg);
            code_index_reg <= emit_cin;
            byte1_reg      <= emit_b1;
            byte2_reg      <= emit_b2;
            byte3_reg      <= emit_b3;
        end
    end

    assign packet_valid = packet_valid_reg;
    assign cable_out    = cable_out_reg;
    assign code_index   = code_index_reg;
    assign byte1        = byte1_reg;
    assign byte2        = byte2_reg;
    assign byte3        = byte3_reg;

endmodule

// ----- test/midi_byte_to_usb_event_packer_tb.sv -----
// ----------------------------------------------------------------------------
// MIDI byte to USB event packer testbench
// Feeds tagged MIDI bytes on all cables through the byte channel, predicts
// every USB-MIDI event packet with a per-cable parser of its own, and checks
// each packet beat field by field under several idle and stall mixes and one
// long packet hold-off.
// ----------------------------------------------------------------------------
module midi_byte_to_usb_event_packer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One USB-MIDI event packet as the packet channel carries it
    typedef struct packed {
        logic [mbup_pkg::CABLE_OUT_W-1:0] cable;
        logic [3:0]                       cin;
        logic [7:0]                       data1;
        logic [7:0]                       data2;
        logic [7:0]                       data3;
    } usb_packet_t;

    // One byte-channel beat: a MIDI byte and the jack it came from
    typedef struct packed {
        logic [mbup_pkg::CABLE_W-1:0] cable;
        logic [7:0]                   midi;
    } midi_beat_t;

    typedef logic [7:0] midi_seq_t [$];

    localparam int SCRIPT_MAX     = 32;
    localparam int RANDOM_BYTES   = 410;
    localparam int PRESSURE_NOTES = 40;
    localparam int HOLD_OFF_LEN   = 250;
    localparam int TAIL_CYCLES    = 8;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             byte_valid   = 1'b0;
    logic                             byte_stall;
    logic [mbup_pkg::CABLE_W-1:0]     cable        = '0;
    logic [7:0]                       rx_byte      = '0;
    logic                             packet_valid;
    logic                             packet_stall = 1'b0;
    logic [mbup_pkg::CABLE_OUT_W-1:0] cable_out;
    logic [3:0]                       code_index;
    logic [7:0]                       byte1;
    logic [7:0]                       byte2;
    logic [7:0]                       byte3;

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    midi_beat_t              byte_feed [$];      // bytes waiting for the driver
    usb_packet_t             packets_due [$];    // predicted packets, oldest first
    mbup_pkg::parser_state_t jack_state [mbup_pkg::CABLES];

    // Per-cable message scripts for the random part; bytes of different
    // cables interleave while each cable still sees whole messages
    logic [7:0]    script [mbup_pkg::CABLES][SCRIPT_MAX];
    int            script_len [mbup_pkg::CABLES];
    int            script_pos [mbup_pkg::CABLES];

    int unsigned   send_idle_pct     = 0;
    int unsigned   stall_pct         = 0;
    int            hold_off_cycles   = 0;
    bit            byte_fire         = 1'b0;
    int            bytes_queued      = 0;
    int            bytes_taken       = 0;
    int            packets_checked   = 0;
    int            mismatch_count    = 0;
    int            input_stall_beats = 0;

    midi_byte_to_usb_event_packer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .cable        (cable),
        .rx_byte      (rx_byte),
        .packet_valid (packet_valid),
        .packet_stall (packet_stall),
        .cable_out    (cable_out),
        .code_index   (code_index),
        .byte1        (byte1),
        .byte2        (byte2),
        .byte3        (byte3)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Packet predictor: per-cable parser copy, advanced once per taken byte
    // ------------------------------------------------------------------
    function automatic mbup_pkg::parser_state_t open_message(logic [7:0] status,
                                                             logic [2:0] kind,
                                                             logic sys);
        mbup_pkg::parser_state_t s;
        s                  = mbup_pkg::STATE_RESET;
        s.held_first       = status;
        s.message_kind     = kind;
        s.system_flag      = sys;
        s.parse_phase      = (kind == mbup_pkg::KIND_SYSEX) ?
                             mbup_pkg::PH_SYSEX : mbup_pkg::PH_WAIT1;
        s.sysex_held_count = (kind == mbup_pkg::KIND_SYSEX) ? 2'd1 : 2'd0;
        return s;
    endfunction

    // Channel messages carry the status nibble; system common uses length
    function automatic logic [3:0] message_cin(mbup_pkg::parser_state_t s);
        if (s.system_flag)
            return (s.message_kind == mbup_pkg::KIND_THREE) ?
                   mbup_pkg::CIN_SYS_THREE : mbup_pkg::CIN_SYS_TWO;
        return s.held_first[7:4];
    endfunction

    function automatic bit pack_rx_byte(input logic [mbup_pkg::CABLE_W-1:0] jack,
                                        input logic [7:0] b, output usb_packet_t pkt);
        mbup_pkg::parser_state_t s;
        bit                      emit;
        s         = jack_state[jack];
        emit      = 1'b0;
        pkt       = '0;
        pkt.cable = mbup_pkg::CABLE_OUT_W'(jack);
        if (b[7])
        begin
            if (b == mbup_pkg::ST_SYSEX_END)
            begin
                // Close a SysEx with whatever is held; a stray end just idles
                if (s.parse_phase == mbup_pkg::PH_SYSEX)
                begin
                    emit = 1'b1;
                    case (s.sysex_held_count)
                        2'd0:
                        begin
                            pkt.cin   = mbup_pkg::CIN_SYSEX_END1;
                            pkt.data1 = b;
                        end
                        2'd1:
                        begin
                            pkt.cin   = mbup_pkg::CIN_SYSEX_END2;
                            pkt.data1 = s.held_first;
                            pkt.data2 = b;
                        end
                        default:
                        begin
                            pkt.cin   = mbup_pkg::CIN_SYSEX_END3;
                            pkt.data1 = s.held_first;
                            pkt.data2 = s.held_second;
                            pkt.data3 = b;
                        end
                    endcase
                    s.message_kind = mbup_pkg::KIND_SYSEX;
                end
                else
                    s.message_kind = mbup_pkg::KIND_NONE;
                s.parse_phase      = mbup_pkg::PH_IDLE;
                s.system_flag      = 1'b1;
                s.sysex_held_count = 2'd0;
            end
            else if (b == mbup_pkg::ST_SYSEX_START)
                s = open_message(b, mbup_pkg::KIND_SYSEX, 1'b1);
            else if (b == mbup_pkg::ST_MTC_QFRAME || b == mbup_pkg::ST_SONG_SEL)
                s = open_message(b, mbup_pkg::KIND_TWO, 1'b1);
            else if (b == mbup_pkg::ST_SONG_POS)
                s = open_message(b, mbup_pkg::KIND_THREE, 1'b1);
            else if (b >= mbup_pkg::ST_FIRST_ONE)
            begin
                s.held_first       = b;
                s.parse_phase      = mbup_pkg::PH_IDLE;
                s.message_kind     = mbup_pkg::KIND_ONE;
                s.system_flag      = 1'b1;
                s.sysex_held_count = 2'd0;
                emit               = 1'b1;
                pkt.cin            = mbup_pkg::CIN_SINGLE;
                pkt.data1          = b;
            end
            else if (b >= mbup_pkg::ST_PROG_CHANGE && b < mbup_pkg::ST_PITCH_BEND)
                s = open_message(b, mbup_pkg::KIND_TWO, 1'b0);
            else
                s = open_message(b, mbup_pkg::KIND_THREE, 1'b0);
        end
        else
        begin
            case (s.parse_phase) inside
                mbup_pkg::PH_WAIT1, mbup_pkg::PH_DONE:
                    if (!(s.parse_phase == mbup_pkg::PH_DONE && s.system_flag))
                    begin
                        s.held_second = b;
                        if (s.message_kind == mbup_pkg::KIND_THREE)
                            s.parse_phase = mbup_pkg::PH_WAIT2;
                        else if (s.message_kind == mbup_pkg::KIND_TWO)
                        begin
                            emit          = 1'b1;
                            pkt.cin       = message_cin(s);
                            pkt.data1     = s.held_first;
                            pkt.data2     = b;
                            s.parse_phase = s.system_flag ?
                                            mbup_pkg::PH_IDLE : mbup_pkg::PH_DONE;
                        end
                        else
                            s.parse_phase = mbup_pkg::PH_IDLE;
                    end
                mbup_pkg::PH_WAIT2:
                    if (s.message_kind != mbup_pkg::KIND_THREE)
                        s.parse_phase = mbup_pkg::PH_IDLE;
                    else
                    begin
                        emit          = 1'b1;
                        pkt.cin       = message_cin(s);
                        pkt.data1     = s.held_first;
                        pkt.data2     = s.held_second;
                        pkt.data3     = b;
                        s.parse_phase = s.system_flag ?
                                        mbup_pkg::PH_IDLE : mbup_pkg::PH_DONE;
                    end
                mbup_pkg::PH_SYSEX:
                    if (s.sysex_held_count == 2'd0)
                    begin
                        s.held_first       = b;
                        s.sysex_held_count = 2'd1;
                    end
                    else if (s.sysex_held_count == 2'd1)
                    begin
                        s.held_second      = b;
                        s.sysex_held_count = 2'd2;
                    end
                    else
                    begin
                        // Third SysEx byte completes a group: send it right away
                        emit               = 1'b1;
                        pkt.cin            = mbup_pkg::CIN_SYSEX_CONT;
                        pkt.data1          = s.held_first;
                        pkt.data2          = s.held_second;
                        pkt.data3          = b;
                        s.sysex_held_count = 2'd0;
                    end
                default: ;
            endcase
        end
        jack_state[jack] = s;
        return emit;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next byte at the falling edge; hold a stalled beat
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : byte_driver
        midi_beat_t beat;
        if (rst_n && !(byte_valid && !byte_fire))
        begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                beat = byte_feed.pop_front();
                cable      <= beat.cable;
                rx_byte    <= beat.midi;
                byte_valid <= 1'b1;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Receiver: count down a requested hold-off, else stall at random
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            packet_stall <= 1'b1;
            hold_off_cycles--;
        end
        else
            packet_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, predict from each byte beat and compare
    // each packet beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : packet_monitor
        usb_packet_t want;
        if (rst_n)
        begin
            byte_fire = byte_valid && !byte_stall;
            if (byte_valid && byte_stall)
                input_stall_beats++;
            if (byte_fire)
            begin
                bytes_taken++;
                if (pack_rx_byte(cable, rx_byte, want))
                    packets_due.push_back(want);
            end
            if (packet_valid && !packet_stall)
            begin
                if (packets_due.size() == 0)
                begin
                    $error("unexpected packet: cable 0x%0h cin 0x%0h bytes %h %h %h",
                           cable_out, code_index, byte1, byte2, byte3);
                    mismatch_count++;
                end
                else
                begin
                    want = packets_due.pop_front();
                    check_field("cable_out", want.cable, cable_out);
                    check_field("code_index", want.cin, code_index);
                    check_field("byte1", want.data1, byte1);
                    check_field("byte2", want.data2, byte2);
                    check_field("byte3", want.data3, byte3);
                    packets_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(int jack, logic [7:0] b);
        midi_beat_t beat;
        beat.cable = mbup_pkg::CABLE_W'(jack);
        beat.midi  = b;
        byte_feed.push_back(beat);
        bytes_queued++;
    endtask

    task automatic queue_bytes(int jack, midi_seq_t seq);
        foreach (seq[i])
            queue_byte(jack, seq[i]);
    endtask

    // Data bytes lean toward the extremes now and then
    function automatic logic [7:0] pick_data();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(127));
        endcase
    endfunction

    task automatic add_to_script(int jack, logic [7:0] b);
        script[jack][script_len[jack]] = b;
        script_len[jack]++;
    endtask

    // Write the next message for one cable; mostly well formed, some noise
    task automatic compose_message(int jack);
        int         pick;
        int         groups;
        logic [7:0] status;
        script_len[jack] = 0;
        script_pos[jack] = 0;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // Channel message plus a few running-status repeats
            status = 8'h80 | 8'($urandom_range(8'h6F));
            add_to_script(jack, status);
            groups = $urandom_range(3);
            for (int g = 0; g <= groups; g++)
            begin
                add_to_script(jack, pick_data());
                if (!(status >= mbup_pkg::ST_PROG_CHANGE &&
                      status < mbup_pkg::ST_PITCH_BEND))
                    add_to_script(jack, pick_data());
            end
        end
        else if (pick < 56)
        begin
            // 0-12 byte SysEx; most end properly, some get cut by a status
            add_to_script(jack, mbup_pkg::ST_SYSEX_START);
            groups = $urandom_range(12);
            for (int g = 0; g < groups; g++)
                add_to_script(jack, pick_data());
            if ($urandom_range(99) < 80)
                add_to_script(jack, mbup_pkg::ST_SYSEX_END);
            else
                add_to_script(jack, 8'($urandom_range(8'h80, 8'hF6)));
        end
        else if (pick < 66)
        begin
            // System common, now and then trailed by a stray data byte
            case ($urandom_range(2))
                0:       status = mbup_pkg::ST_MTC_QFRAME;
                1:       status = mbup_pkg::ST_SONG_SEL;
                default: status = mbup_pkg::ST_SONG_POS;
            endcase
            add_to_script(jack, status);
            add_to_script(jack, pick_data());
            if (status == mbup_pkg::ST_SONG_POS)
                add_to_script(jack, pick_data());
            if ($urandom_range(3) == 0)
                add_to_script(jack, pick_data());
        end
        else if (pick < 78)
        begin
            // Single-byte message, sometimes followed by stray data
            if ($urandom_range(3) == 0)
                status = 8'($urandom_range(mbup_pkg::ST_FIRST_ONE, 8'hF6));
            else
                status = 8'($urandom_range(8'hF8, 8'hFF));
            add_to_script(jack, status);
            if ($urandom_range(2) == 0)
                add_to_script(jack, pick_data());
        end
        else if (pick < 85)
            add_to_script(jack, mbup_pkg::ST_SYSEX_END);
        else
        begin
            groups = $urandom_range(1, 3);
            for (int g = 0; g < groups; g++)
                add_to_script(jack, 8'($urandom_range(255)));
        end
    endtask

    // Draw bytes from the cable scripts; stay on one cable half the time
    task automatic queue_random(int count);
        int jack;
        jack = 0;
        repeat (count)
        begin
            if ($urandom_range(1))
                jack = $urandom_range(mbup_pkg::CABLES - 1);
            if (script_pos[jack] == script_len[jack])
                compose_message(jack);
            queue_byte(jack, script[jack][script_pos[jack]]);
            script_pos[jack]++;
        end
    endtask

    // bytes_taken and the prediction queue move only at the rising edge
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || packets_due.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned idle_plan [4];
        int unsigned stall_plan [4];
        idle_plan  = '{0, 78, 0, 12};
        stall_plan = '{0, 0, 78, 12};
        foreach (jack_state[j])
        begin
            jack_state[j] = mbup_pkg::STATE_RESET;
            script_len[j] = 0;
            script_pos[j] = 0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: note on split across cables, then running status
        queue_bytes(0, '{8'h90, 8'h3C});
        queue_bytes(1, '{8'hC5});
        queue_bytes(0, '{8'h7F, 8'h00, 8'h00});
        queue_bytes(1, '{8'h7F, 8'h00});
        // Song position with extreme data, quarter frame with a stray byte
        queue_bytes(2, '{8'hF2, 8'h00, 8'h7F});
        queue_bytes(3, '{8'hF1, 8'h12, 8'h55});
        // Single-byte messages
        queue_bytes(1, '{8'hF8, 8'hFF});
        // SysEx: one full group then an end holding two bytes
        queue_bytes(2, '{8'hF0, 8'h01, 8'h02, 8'h03, 8'h04, 8'hF7});
        // Empty SysEx closes with the start byte held
        queue_bytes(3, '{8'hF0, 8'hF7});
        // SysEx cut short by a note on, then a stray end
        queue_bytes(0, '{8'hF0, 8'h7E, 8'h90, 8'h3C, 8'h40, 8'hF7});
        wait_drained();

        // Random phases: no idling, sender gaps, receiver stalls, both light
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            queue_random(RANDOM_BYTES);
            wait_drained();
        end

        // Pressure: hold the packet side off while notes keep coming, so the
        // packer fills and raises byte_stall
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_off_cycles = HOLD_OFF_LEN;
        for (int n = 0; n < PRESSURE_NOTES; n++)
            queue_bytes(n % mbup_pkg::CABLES, '{8'h90 | 8'($urandom_range(15)),
                                                pick_data(), pick_data()});
        wait_drained();

        // Let any packet the block should not send show up before deciding
        repeat (TAIL_CYCLES) @(posedge clk);
        if (packets_due.size() != 0)
        begin
            $error("%0d predicted packets never arrived", packets_due.size());
            mismatch_count++;
        end

        $display("Run covered %0d MIDI bytes on %0d cables and %0d checked packets;",
                 bytes_taken, mbup_pkg::CABLES, packets_checked);
        $display("the byte side saw back-pressure on %0d cycles.", input_stall_beats);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2_000_000;
        $error("timeout: %0d of %0d bytes taken, %0d packets outstanding",
               bytes_taken, bytes_queued, packets_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- midi_byte_to_usb_event_packer.f -----
rtl/core/mbup_pkg.sv
rtl/core/midi_byte_to_usb_event_packer.sv
test/midi_byte_to_usb_event_packer_tb.sv
